[rtl/mcsba_pkg.sv]
// ----------------------------------------------------------------------------
// mcsba_pkg
// Shared types and constants of the multi-class slab block allocator: item
// layouts, operation and status codes, configuration register indexes.
// ----------------------------------------------------------------------------
package mcsba_pkg;

  localparam int BYTES_W    = 21;
  localparam int BASE_W     = 48;
  localparam int SIZE_W     = 32;
  localparam int CLASS_W    = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int WORD_W     = 64;

  // Only four classes have configuration registers.
  localparam int CFG_CLASSES = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTES0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE0  = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED    = 3'd0,
    ST_NO_BLOCK     = 3'd1,
    ST_FREED        = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_UNKNOWN      = 3'd4
  } status_e;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [BASE_W-1:0] buffer_address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BASE_W-1:0]   block_address;
    logic [BYTES_W-1:0]  block_bytes;
    logic [CLASS_W-1:0]  class_index;
  } rsp_t;

endpackage

[rtl/mcsba_bitmap.sv]
// ----------------------------------------------------------------------------
// mcsba_bitmap
// Free-block bitmap store: one 64-bit word per row, rows addressed by class
// and word. One write and one registered read per cycle. A row never written
// since reset reads as its reset pattern (all blocks free).
// ----------------------------------------------------------------------------
module mcsba_bitmap #(
  parameter int  NUM_CLASSES      = 4,
  parameter int  BLOCKS_PER_CLASS = 64,
  localparam int WORDS_P = (BLOCKS_PER_CLASS + mcsba_pkg::WORD_W - 1) / mcsba_pkg::WORD_W,
  localparam int CLSW_P  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
  localparam int WW_P    = (WORDS_P > 1) ? $clog2(WORDS_P) : 1
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        rd_en_i,
  input  logic [CLSW_P+WW_P-1:0]                      rd_addr_i,
  output logic [mcsba_pkg::WORD_W-1:0]                rd_data_o,
  input  logic                                        wr_en_i,
  input  logic [CLSW_P+WW_P-1:0]                      wr_addr_i,
  input  logic [mcsba_pkg::WORD_W-1:0]                wr_data_i
);
  import mcsba_pkg::*;

  localparam int WORDS  = WORDS_P;
  localparam int WW     = WW_P;
  localparam int DEPTH  = NUM_CLASSES * (2 ** WW);
  localparam int TAIL   = BLOCKS_PER_CLASS % WORD_W;
  localparam logic [WORD_W-1:0] LAST_WORD =
    (TAIL == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TAIL) - WORD_W'(1));

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;
  logic [WW-1:0]     rword_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      rword_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q  <= vld_q[rd_addr_i];
        rword_q <= rd_addr_i[WW-1:0];
      end
    end
  end

  // Unwritten rows read as free; the last word of a class holds only the tail.
  assign rd_data_o = rvld_q ? rdata_q :
                     ((rword_q == WW'(WORDS - 1)) ? LAST_WORD : {WORD_W{1'b1}});

endmodule

[rtl/multi_class_slab_block_allocator.sv]
// ----------------------------------------------------------------------------
// multi_class_slab_block_allocator
// Slab allocator over up to NUM_CLASSES size classes with a free bitmap and a
// free count per class. Allocate takes the lowest free block of the first
// fitting class; free locates the class, divides the offset, sets the bit.
// ----------------------------------------------------------------------------
// Sequence: allocate checks classes, reads bitmap words until a nonzero one, scans
//   it byte by byte, multiplies and adds the base; free checks classes, divides the
//   offset bit by bit, reads the word, sets the bit if clear; zero address is unknown.
// Throughput: one item at a time, set by the sequencer around the shared
//   multiplier and subtractor; a finished item waits in the output register.
// Reset: counts load BLOCKS_PER_CLASS, configuration clears; bitmap rows use valid bits.
module multi_class_slab_block_allocator #(
  parameter int NUM_CLASSES      = 4,
  parameter int BLOCKS_PER_CLASS = 64,
  parameter int ADDR_BITS        = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mcsba_pkg::req_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mcsba_pkg::rsp_t                      out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [mcsba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mcsba_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mcsba_pkg::*;

  localparam int WORDS = (BLOCKS_PER_CLASS + WORD_W - 1) / WORD_W;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CLSW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int IW    = WW + 6;              // block index: word and bit
  localparam int MAW   = IW + 1;              // multiplier index operand
  localparam int PW    = MAW + BYTES_W;       // product
  localparam int RW    = IW + BYTES_W;        // division remainder
  localparam int STW   = $clog2(IW);
  localparam int CW    = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int AW    = CLSW + WW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_ACHK  = 11'b000_0000_0010,
    S_AWORD = 11'b000_0000_0100,
    S_ASCAN = 11'b000_0000_1000,
    S_AMUL  = 11'b000_0001_0000,
    S_AADD  = 11'b000_0010_0000,
    S_FCHK  = 11'b000_0100_0000,
    S_FCMP  = 11'b000_1000_0000,
    S_FDIV  = 11'b001_0000_0000,
    S_FRD   = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [BYTES_W-1:0]   bs_q   [NUM_CLASSES];
  logic [BASE_W-1:0]    base_q [NUM_CLASSES];
  logic [CW-1:0]        cnt_q  [NUM_CLASSES];

  logic [CLSW-1:0]      cls_q, cls_d;
  logic [WW-1:0]        w_q, w_d;
  logic [5:0]           bit_q, bit_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic [WORD_W-1:0]    scan_q, scan_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [ADDR_BITS-1:0] off_q, off_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [RW-1:0]        dvs_q, dvs_d;
  logic [IW-1:0]        quo_q, quo_d;
  logic [STW-1:0]       step_q, step_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  rsp_t                 res_q, res_d;
  rsp_t                 out_q;
  logic                 out_valid_q;
  logic                 out_load;
  logic                 cnt_inc, cnt_dec;

  logic [BYTES_W-1:0]   bs_cur;
  logic [CW-1:0]        cnt_cur;
  logic [63:0]          base64, addr64_in, off64, prod64, sum64, sum_out64;
  logic [ADDR_BITS-1:0] base_cur, addr_in, off_now, sum_a;
  logic [7:0]           cls8;
  logic [CLASS_W-1:0]   cls_out;
  logic                 last_cls;
  logic [2:0]           low_pos;
  logic [MAW-1:0]       mul_a;
  logic [PW-1:0]        mul_p;
  logic [RW:0]          trial;

  logic                 mem_rd_en, mem_wr_en;
  logic [AW-1:0]        mem_rd_addr, mem_wr_addr;
  logic [WORD_W-1:0]    mem_rd_data, mem_wr_data;

  mcsba_bitmap #(
    .NUM_CLASSES      (NUM_CLASSES),
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  assign bs_cur    = bs_q[cls_q];
  assign cnt_cur   = cnt_q[cls_q];
  assign base64    = 64'(base_q[cls_q]);
  assign base_cur  = base64[ADDR_BITS-1:0];
  assign addr64_in = 64'(in_data_i.buffer_address);
  assign addr_in   = addr64_in[ADDR_BITS-1:0];
  assign off_now   = addr_q - base_cur;
  assign off64     = 64'(off_q);
  assign prod64    = 64'(prod_q);
  assign sum64     = 64'(base_cur) + prod64;
  assign sum_a     = sum64[ADDR_BITS-1:0];
  assign sum_out64 = 64'(sum_a);
  assign cls8      = 8'(cls_q);
  assign cls_out   = cls8[CLASS_W-1:0];
  assign last_cls  = (cls_q == CLSW'(NUM_CLASSES - 1));

  // Shared units: one multiplier, one trial subtractor.
  assign mul_p = PW'(mul_a) * PW'(bs_cur);
  assign trial = {1'b0, rem_q} - {1'b0, dvs_q};

  always_comb begin
    low_pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (scan_q[k]) begin
        low_pos = 3'(k);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cls_d       = cls_q;
    w_d         = w_q;
    bit_d       = bit_q;
    word_d      = word_q;
    scan_d      = scan_q;
    prod_d      = prod_q;
    off_d       = off_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    step_d      = step_q;
    size_d      = size_q;
    addr_d      = addr_q;
    res_d       = res_q;
    mul_a       = MAW'(BLOCKS_PER_CLASS);
    mem_rd_en   = 1'b0;
    mem_rd_addr = {cls_q, w_q};
    mem_wr_en   = 1'b0;
    mem_wr_addr = {cls_q, w_q};
    mem_wr_data = word_q;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          size_d = in_data_i.request_size;
          addr_d = addr_in;
          cls_d  = '0;
          if (in_data_i.operation == OP_ALLOC) begin
            state_d = S_ACHK;
          end else if (addr_in == '0) begin
            res_d   = '{status: ST_UNKNOWN, block_address: '0, block_bytes: '0,
                        class_index: '0};
            state_d = S_FIN;
          end else begin
            state_d = S_FCHK;
          end
        end
      end
      S_ACHK: begin
        if (bs_cur != '0 && SIZE_W'(bs_cur) >= size_q && cnt_cur != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {cls_q, WW'(0)};
          w_d         = '0;
          state_d     = S_AWORD;
        end else if (last_cls) begin
          res_d   = '{status: ST_NO_BLOCK, block_address: '0, block_bytes: '0,
                      class_index: '0};
          state_d = S_FIN;
        end else begin
          cls_d = cls_q + CLSW'(1);
        end
      end
      S_AWORD: begin
        // The free count guarantees a nonzero word within the class.
        if (mem_rd_data == '0) begin
          w_d         = w_q + WW'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = {cls_q, w_q + WW'(1)};
        end else begin
          word_d  = mem_rd_data;
          scan_d  = mem_rd_data;
          bit_d   = '0;
          state_d = S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (scan_q[7:0] != '0) begin
          bit_d   = bit_q + 6'(low_pos);
          state_d = S_AMUL;
        end else begin
          scan_d = scan_q >> 8;
          bit_d  = bit_q + 6'd8;
        end
      end
      S_AMUL: begin
        mul_a       = {1'b0, w_q, bit_q};
        prod_d      = mul_p;
        mem_wr_en   = 1'b1;
        mem_wr_data = word_q & ~(WORD_W'(1) << bit_q);
        cnt_dec     = 1'b1;
        state_d     = S_AADD;
      end
      S_AADD: begin
        res_d   = '{status: ST_ALLOCATED, block_address: sum_out64[BASE_W-1:0],
                    block_bytes: bs_cur, class_index: cls_out};
        state_d = S_FIN;
      end
      S_FCHK: begin
        if (bs_cur == '0 || addr_q < base_cur) begin
          if (last_cls) begin
            res_d   = '{status: ST_UNKNOWN, block_address: '0, block_bytes: '0,
                        class_index: '0};
            state_d = S_FIN;
          end else begin
            cls_d = cls_q + CLSW'(1);
          end
        end else begin
          off_d   = off_now;
          prod_d  = mul_p;          // region length: block size times blocks
          state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (off64 >= prod64) begin
          if (last_cls) begin
            res_d   = '{status: ST_UNKNOWN, block_address: '0, block_bytes: '0,
                        class_index: '0};
            state_d = S_FIN;
          end else begin
            cls_d   = cls_q + CLSW'(1);
            state_d = S_FCHK;
          end
        end else begin
          rem_d   = off64[RW-1:0];
          dvs_d   = RW'(bs_cur) << (IW - 1);
          quo_d   = '0;
          step_d  = STW'(IW - 1);
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        // One quotient bit per cycle, most significant first.
        if (!trial[RW]) begin
          rem_d         = trial[RW-1:0];
          quo_d[step_q] = 1'b1;
        end
        dvs_d = dvs_q >> 1;
        if (step_q == '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {cls_q, quo_d[IW-1:6]};
          state_d     = S_FRD;
        end else begin
          step_d = step_q - STW'(1);
        end
      end
      S_FRD: begin
        if (mem_rd_data[quo_q[5:0]]) begin
          res_d = '{status: ST_ALREADY_FREE, block_address: '0, block_bytes: '0,
                    class_index: cls_out};
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = {cls_q, quo_q[IW-1:6]};
          mem_wr_data = mem_rd_data | (WORD_W'(1) << quo_q[5:0]);
          cnt_inc     = 1'b1;
          res_d       = '{status: ST_FREED, block_address: '0, block_bytes: '0,
                          class_index: cls_out};
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    w_q    <= w_d;
    bit_q  <= bit_d;
    word_q <= word_d;
    scan_q <= scan_d;
    prod_q <= prod_d;
    off_q  <= off_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    size_q <= size_d;
    addr_q <= addr_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_q[c] <= CW'(BLOCKS_PER_CLASS);
      end
    end else if (cnt_dec) begin
      cnt_q[cls_q] <= cnt_cur - CW'(1);
    end else if (cnt_inc) begin
      cnt_q[cls_q] <= cnt_cur + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        bs_q[c]   <= '0;
        base_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg_we_i && c < CFG_CLASSES) begin
          if (cfg_index_i == CFG_BYTES0 + CFG_IDX_W'(c)) begin
            bs_q[c] <= cfg_wdata_i[BYTES_W-1:0];
          end
          if (cfg_index_i == CFG_BASE0 + CFG_IDX_W'(c)) begin
            base_q[c] <= cfg_wdata_i[BASE_W-1:0];
          end
        end
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
